FILE: hw/rtl/drto_pkg.sv
package drto_pkg;

  localparam int MaxNodesDefault = 64;
  localparam int NodeW = 6;

  localparam logic [1:0] CmdAddEdge = 2'd0;
  localparam logic [1:0] CmdRun     = 2'd1;
  localparam logic [1:0] CmdClear   = 2'd2;
  localparam logic [1:0] CmdRsvd    = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [NodeW-1:0] upstream_node;
    logic [NodeW-1:0] dependent_node;
    logic [NodeW-1:0] root_node;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [NodeW-1:0] discovered_by;
    logic             is_root;
    logic             cycle_error;
    logic             last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_cmd;    // latch input beat
    logic add_edge;
    logic clr_step;    // clear one adjacency row
    logic walk_init;
    logic walk_pop;    // pop stack top, read its row
    logic walk_scan;   // push one fresh dependent
    logic deg_init;
    logic deg_step;    // add one marked row into in-degree
    logic ready_init;
    logic kahn_pick;   // take lowest ready, read row
    logic kahn_apply;  // apply picked row to all in-degree lanes
    logic emit_init;
    logic emit_step;   // advance order buffer index
    logic out_load;
    logic out_cycle;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       node_ok;
    logic       stack_empty;
    logic       fresh_any;
    logic       cnt_done;
    logic       ready_any;
    logic       order_ok;
    logic       emit_last;
  } dp_stat_t;

endpackage

FILE: hw/rtl/drto_if.sv
interface drto_in_if;
  logic                     valid;
  logic                     ready;
  drto_pkg::in_item_t       data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface drto_out_if;
  logic                     valid;
  logic                     ready;
  drto_pkg::out_item_t      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/drto_ram.sv
module drto_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/drto_datapath.sv
module drto_datapath #(
  parameter int MaxNodes = drto_pkg::MaxNodesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  drto_pkg::in_item_t  in_data,
  input  drto_pkg::dp_cmd_t   c,
  output drto_pkg::dp_stat_t  s,
  output drto_pkg::out_item_t out_data
);
  localparam int NW = drto_pkg::NodeW;
  localparam int AW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;

  drto_pkg::in_item_t cur_in;
  logic [NW-1:0] root;
  logic [MaxNodes-1:0] marked;
  logic [MaxNodes-1:0] ready_set;
  logic [MaxNodes-1:0] fresh;
  logic [MaxNodes-1:0] fresh_eff, fresh_rest;
  logic          fresh_load;
  logic [NW-1:0] cur;
  logic [NW:0]   sp;
  logic [NW:0]   cnt;
  logic [NW:0]   marked_count;
  logic [NW:0]   ordered;
  logic [NW:0]   emit_idx;
  logic [6:0]    in_degree [MaxNodes];

  // adjacency RAM: read/modify/write
  logic                we_adj;
  logic [AW-1:0]       adj_waddr, adj_raddr;
  logic [MaxNodes-1:0] adj_wdata, adj_rdata;

  logic          we_disc, we_stk, we_ord;
  logic [AW-1:0] disc_waddr, disc_raddr, stk_waddr, stk_raddr, ord_waddr, ord_raddr;
  logic [NW-1:0] disc_wdata, disc_rdata, stk_wdata, stk_rdata, ord_wdata, ord_rdata;

  drto_ram #(.Width(MaxNodes), .Depth(MaxNodes)) u_adj (
    .clk, .we(we_adj), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata));
  drto_ram #(.Width(NW), .Depth(MaxNodes)) u_disc (
    .clk, .we(we_disc), .waddr(disc_waddr), .wdata(disc_wdata),
    .raddr(disc_raddr), .rdata(disc_rdata));
  drto_ram #(.Width(NW), .Depth(MaxNodes)) u_stk (
    .clk, .we(we_stk), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));
  drto_ram #(.Width(NW), .Depth(MaxNodes)) u_ord (
    .clk, .we(we_ord), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata));

  function automatic logic [AW-1:0] lowest(input logic [MaxNodes-1:0] v);
    logic [AW-1:0] r;
    r = '0;
    for (int i = MaxNodes - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = AW'(i);
      end
    end
    return r;
  endfunction

  // fresh mask comes straight from the row in the cycle after a pop
  assign fresh_eff = fresh_load ? (adj_rdata & ~marked) : fresh;

  logic [AW-1:0] fresh_low, ready_low;
  assign fresh_low = lowest(fresh_eff);
  assign ready_low = lowest(ready_set);

  always_comb begin
    fresh_rest = fresh_eff;
    fresh_rest[fresh_low] = 1'b0;
  end

  // adjacency read address: edge add reads upstream; walk/deg/kahn read
  // rows chosen by controller phase
  logic [AW-1:0] stk_top;
  assign stk_top = AW'(sp - 1'b1);

  always_comb begin
    adj_raddr = AW'(in_data.upstream_node);
    if (c.walk_pop) begin
      adj_raddr = AW'(stk_rdata);
    end else if (c.deg_step || c.deg_init) begin
      adj_raddr = AW'(cnt);
    end else if (c.kahn_pick) begin
      adj_raddr = ready_low;
    end else if (c.load_cmd) begin
      adj_raddr = AW'(in_data.upstream_node);
    end else begin
      adj_raddr = AW'(cur_in.upstream_node);
    end
  end

  // edge add: row is read the cycle after load, written on add_edge
  assign we_adj    = c.add_edge || c.clr_step;
  assign adj_waddr = c.clr_step ? AW'(cnt) : AW'(cur_in.upstream_node);
  always_comb begin
    adj_wdata = '0;
    if (c.add_edge) begin
      adj_wdata = adj_rdata;
      adj_wdata[AW'(cur_in.dependent_node)] = 1'b1;
    end
  end

  assign we_disc    = c.walk_init || c.walk_scan;
  assign disc_waddr = c.walk_init ? AW'(cur_in.root_node) : fresh_low;
  assign disc_wdata = c.walk_init ? cur_in.root_node : cur;
  assign disc_raddr = AW'(ord_rdata);

  assign we_stk    = c.walk_init || c.walk_scan;
  assign stk_waddr = c.walk_init ? '0 : AW'(sp);
  assign stk_wdata = c.walk_init ? cur_in.root_node : NW'(fresh_low);
  assign stk_raddr = stk_top;

  assign we_ord    = c.kahn_pick;
  assign ord_waddr = AW'(ordered);
  assign ord_wdata = NW'(ready_low);
  assign ord_raddr = AW'(emit_idx);

  always_ff @(posedge clk) begin
    if (c.load_cmd) begin
      cur_in <= in_data;
    end
    if (c.walk_init) begin
      root <= cur_in.root_node;
      sp <= (NW+1)'(1);
      marked_count <= (NW+1)'(1);
      fresh <= '0;
    end
    if (c.walk_pop) begin
      cur <= stk_rdata;
      sp <= sp - 1'b1;
    end
    if (c.walk_scan) begin
      fresh <= fresh_rest;
      marked[fresh_low] <= 1'b1;
      if (sp < (NW+1)'(MaxNodes)) begin
        sp <= sp + 1'b1;
      end
      marked_count <= marked_count + 1'b1;
    end
    if (c.clr_step || c.deg_step) begin
      cnt <= cnt + 1'b1;
    end
    if (rst || c.load_cmd || c.deg_init) begin
      cnt <= '0;
    end
    if (c.deg_init) begin
      for (int i = 0; i < MaxNodes; i++) begin
        in_degree[i] <= '0;
      end
    end
    if (c.deg_step && cnt != '0 && marked[AW'(cnt - 1'b1)]) begin
      for (int i = 0; i < MaxNodes; i++) begin
        in_degree[i] <= in_degree[i] + {6'd0, adj_rdata[i] & marked[i]};
      end
    end
    if (c.ready_init) begin
      for (int i = 0; i < MaxNodes; i++) begin
        ready_set[i] <= marked[i] && in_degree[i] == '0;
      end
      ordered <= '0;
    end
    if (c.kahn_pick) begin
      ready_set[ready_low] <= 1'b0;
      ordered <= ordered + 1'b1;
    end
    // row of the picked node is on adj_rdata
    if (c.kahn_apply) begin
      for (int i = 0; i < MaxNodes; i++) begin
        if (adj_rdata[i] && marked[i]) begin
          if (in_degree[i] > 7'd1) begin
            in_degree[i] <= in_degree[i] - 7'd1;
          end else begin
            in_degree[i] <= '0;
            ready_set[i] <= 1'b1;
          end
        end
      end
    end
    if (c.emit_init) begin
      emit_idx <= '0;
    end
    if (c.emit_step) begin
      emit_idx <= emit_idx + 1'b1;
    end
    if (c.out_load) begin
      out_data.node          <= ord_rdata;
      out_data.discovered_by <= disc_rdata;
      out_data.is_root       <= ord_rdata == root;
      out_data.cycle_error   <= 1'b0;
      out_data.last          <= emit_idx == ordered;
    end
    if (c.out_cycle) begin
      out_data.node          <= root;
      out_data.discovered_by <= '0;
      out_data.is_root       <= 1'b1;
      out_data.cycle_error   <= 1'b1;
      out_data.last          <= 1'b1;
    end
    if (rst || c.walk_init) begin
      marked <= '0;
      if (c.walk_init) begin
        marked[AW'(cur_in.root_node)] <= 1'b1;
      end
    end
    if (rst) begin
      ready_set <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_load <= 1'b0;
    end else begin
      fresh_load <= c.walk_pop;
    end
  end

  assign s.cmd         = cur_in.cmd;
  assign s.node_ok     = (cur_in.cmd == drto_pkg::CmdRun) ?
                         ({1'b0, cur_in.root_node} < (NW+1)'(MaxNodes)) :
                         ({1'b0, cur_in.upstream_node} < (NW+1)'(MaxNodes) &&
                          {1'b0, cur_in.dependent_node} < (NW+1)'(MaxNodes));
  assign s.stack_empty = sp == '0;
  assign s.fresh_any   = |fresh_eff;
  assign s.cnt_done    = cnt == (NW+1)'(MaxNodes);
  assign s.ready_any   = |ready_set;
  assign s.order_ok    = ordered == marked_count;
  assign s.emit_last   = emit_idx == ordered;
endmodule

FILE: hw/rtl/drto_ctrl.sv
module drto_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  drto_pkg::dp_stat_t s,
  output drto_pkg::dp_cmd_t  c
);
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SDec   = 4'd1;
  localparam logic [3:0] SAdd   = 4'd2;
  localparam logic [3:0] SClr   = 4'd3;
  localparam logic [3:0] SPop   = 4'd4;
  localparam logic [3:0] SScan  = 4'd5;
  localparam logic [3:0] SDeg   = 4'd6;
  localparam logic [3:0] SRdy   = 4'd7;
  localparam logic [3:0] SPick  = 4'd8;
  localparam logic [3:0] SApply = 4'd9;
  localparam logic [3:0] SEmRd  = 4'd10;
  localparam logic [3:0] SEmLd  = 4'd11;
  localparam logic [3:0] SOut   = 4'd12;
  localparam logic [3:0] SWalk0 = 4'd13;
  localparam logic [3:0] SEmWt  = 4'd14;

  logic [3:0] state, state_next;
  logic       final_beat, final_beat_next;

  assign in_ready  = state == SIdle;
  assign out_valid = state == SOut;

  always_comb begin
    c = '0;
    state_next = state;
    final_beat_next = final_beat;
    case (state)
      SIdle: begin
        if (in_valid) begin
          c.load_cmd = 1'b1;
          state_next = SDec;
        end
      end
      SDec: begin
        if (!s.node_ok && s.cmd != drto_pkg::CmdClear) begin
          state_next = SIdle;
        end else begin
          case (s.cmd)
            drto_pkg::CmdAddEdge: state_next = SAdd;
            drto_pkg::CmdRun: begin
              c.walk_init = 1'b1;
              state_next = SWalk0;
            end
            drto_pkg::CmdClear: state_next = SClr;
            default: state_next = SIdle;
          endcase
        end
      end
      SAdd: begin
        c.add_edge = 1'b1;
        state_next = SIdle;
      end
      SClr: begin
        if (s.cnt_done) begin
          state_next = SIdle;
        end else begin
          c.clr_step = 1'b1;
        end
      end
      SWalk0: begin
        if (s.stack_empty) begin
          c.deg_init = 1'b1;
          state_next = SDeg;
        end else begin
          state_next = SPop;
        end
      end
      // stack top read is valid here
      SPop: begin
        c.walk_pop = 1'b1;
        state_next = SScan;
      end
      SScan: begin
        if (s.fresh_any) begin
          c.walk_scan = 1'b1;
        end else begin
          state_next = SWalk0;
        end
      end
      SDeg: begin
        c.deg_step = 1'b1;
        if (s.cnt_done) begin
          state_next = SRdy;
        end
      end
      SRdy: begin
        c.ready_init = 1'b1;
        state_next = SPick;
      end
      SPick: begin
        if (s.ready_any) begin
          c.kahn_pick = 1'b1;
          state_next = SApply;
        end else if (!s.order_ok) begin
          c.out_cycle = 1'b1;
          final_beat_next = 1'b1;
          state_next = SOut;
        end else begin
          c.emit_init = 1'b1;
          state_next = SEmRd;
        end
      end
      SApply: begin
        c.kahn_apply = 1'b1;
        state_next = SPick;
      end
      SEmRd: state_next = SEmWt;
      SEmWt: begin
        c.emit_step = 1'b1;
        state_next = SEmLd;
      end
      SEmLd: begin
        c.out_load = 1'b1;
        final_beat_next = s.emit_last;
        state_next = SOut;
      end
      SOut: begin
        if (out_ready) begin
          state_next = final_beat ? SIdle : SEmRd;
        end
      end
      default: state_next = SIdle;
    endcase
  end

  // reset starts with a sweep of the adjacency rows
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SClr;
      final_beat <= 1'b0;
    end else begin
      state <= state_next;
      final_beat <= final_beat_next;
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in_ready with out_valid");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_accept_dec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == SDec) else $error("accept lost");
endmodule

FILE: hw/rtl/dependent_reach_topo_order.sv
// Edge add: one beat goes Idle, Dec, Add; clear: Idle, Dec, then one Clr step per
// adjacency row. One item at a time. Run: a walk from the root, an in-degree pass
// over all rows, ordering with a pick and an apply per ordered node, then the result
// beats (a cycle error gives one beat right after ordering).
// Synchronous reset clears control state and the marked and ready sets, then
// sweeps all adjacency rows to zero before the first beat.
module dependent_reach_topo_order #(
  parameter int MaxNodes = drto_pkg::MaxNodesDefault
) (
  input logic     clk,
  input logic     rst,
  drto_in_if.sink    in_ch,
  drto_out_if.source out_ch
);
  drto_pkg::dp_cmd_t  c;
  drto_pkg::dp_stat_t s;

  drto_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .s, .c);

  drto_datapath #(.MaxNodes(MaxNodes)) u_dp (
    .clk, .rst, .in_data(in_ch.data), .c, .s, .out_data(out_ch.data));
endmodule

FILE: bench/dependent_reach_topo_order_tb.sv
`timescale 1ns / 1ps

module dependent_reach_topo_order_tb;

  localparam int StallLimit = 50000;

  logic clk;
  logic rst;

  drto_in_if  in_ch();
  drto_out_if out_ch();

  dependent_reach_topo_order dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  drto_pkg::in_item_t  cmd_queue[$];
  drto_pkg::out_item_t redo_queue[$];

  logic [63:0] graph_rows[64];
  logic [5:0]  found_by[64];

  int errors = 0;
  int stall_cycles = 0;
  int in_idle = 0;
  int out_idle = 0;
  bit draining = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    for (int i = 0; i < 64; i++) graph_rows[i] = '0;
  end

  task automatic add_result(input drto_pkg::out_item_t r);
    redo_queue.insert(redo_queue.size(), r);
  endtask

  task automatic queue_cmd(input drto_pkg::in_item_t it);
    cmd_queue.insert(cmd_queue.size(), it);
  endtask

  task automatic predict_run(input logic [5:0] root);
    logic [63:0] marked;
    logic [63:0] ready_nodes;
    logic [5:0]  stack[64];
    logic [5:0]  order[64];
    int          indeg[64];
    int          sp;
    int          reached;
    int          ordered;
    int          cur;
    drto_pkg::out_item_t r;
    marked = '0;
    marked[root] = 1'b1;
    found_by[root] = root;
    sp = 0;
    stack[sp] = root;
    sp++;
    reached = 1;
    while (sp > 0) begin
      sp--;
      cur = stack[sp];
      for (int d = 0; d < 64; d++) begin
        if (graph_rows[cur][d] && !marked[d]) begin
          marked[d] = 1'b1;
          found_by[d] = cur[5:0];
          if (sp < 64) begin
            stack[sp] = d[5:0];
            sp++;
          end
          reached++;
        end
      end
    end
    for (int i = 0; i < 64; i++) indeg[i] = 0;
    for (int i = 0; i < 64; i++)
      if (marked[i])
        for (int d = 0; d < 64; d++)
          if (graph_rows[i][d] && marked[d]) indeg[d]++;
    ready_nodes = '0;
    for (int i = 0; i < 64; i++)
      if (marked[i] && indeg[i] == 0) ready_nodes[i] = 1'b1;
    ordered = 0;
    while (ready_nodes != '0) begin
      cur = 0;
      while (cur < 63 && !ready_nodes[cur]) cur++;
      ready_nodes[cur] = 1'b0;
      if (ordered < 64) begin
        order[ordered] = cur[5:0];
        ordered++;
      end
      for (int d = 0; d < 64; d++) begin
        if (graph_rows[cur][d] && marked[d]) begin
          if (indeg[d] > 0) indeg[d]--;
          if (indeg[d] == 0) ready_nodes[d] = 1'b1;
        end
      end
    end
    if (ordered != reached) begin
      r.node = root;
      r.discovered_by = '0;
      r.is_root = 1'b1;
      r.cycle_error = 1'b1;
      r.last = 1'b1;
      add_result(r);
    end else begin
      for (int i = 0; i < ordered; i++) begin
        r.node = order[i];
        r.discovered_by = found_by[order[i]];
        r.is_root = (order[i] == root);
        r.cycle_error = 1'b0;
        r.last = (i + 1 == ordered);
        add_result(r);
      end
    end
  endtask

  task automatic apply_cmd(input drto_pkg::in_item_t it);
    case (it.cmd)
      drto_pkg::CmdAddEdge: graph_rows[it.upstream_node][it.dependent_node] = 1'b1;
      drto_pkg::CmdRun:     predict_run(it.root_node);
      drto_pkg::CmdClear:   for (int i = 0; i < 64; i++) graph_rows[i] = '0;
      default: ;
    endcase
  endtask

  function automatic drto_pkg::in_item_t mk(input logic [1:0] c, input int u,
                                            input int d, input int r);
    drto_pkg::in_item_t it;
    it.cmd = c;
    it.upstream_node = u[5:0];
    it.dependent_node = d[5:0];
    it.root_node = r[5:0];
    return it;
  endfunction

  function automatic drto_pkg::in_item_t noise_fields(input logic [1:0] c);
    return mk(c, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_idle <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) apply_cmd(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_idle > 0) begin
          in_idle <= in_idle - 1;
          in_ch.valid <= 1'b0;
        end else if (cmd_queue.size() > 30 && $urandom_range(0, 5) == 0) begin
          in_idle <= $urandom_range(1, 13) - 1;
          in_ch.valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          in_ch.data <= cmd_queue.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    drto_pkg::out_item_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_idle <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (redo_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat %p", out_ch.data);
        end else begin
          want = redo_queue.pop_front();
          if (out_ch.data.node !== want.node ||
              out_ch.data.discovered_by !== want.discovered_by ||
              out_ch.data.is_root !== want.is_root ||
              out_ch.data.cycle_error !== want.cycle_error ||
              out_ch.data.last !== want.last) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", want, out_ch.data);
          end
        end
      end
      if (out_idle > 0) begin
        out_idle <= out_idle - 1;
        out_ch.ready <= 1'b0;
      end else if (!draining && $urandom_range(0, 5) == 0) begin
        out_idle <= $urandom_range(1, 13) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("dependent_reach_topo_order_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int nodes[10];
    int k;
    int a;
    int b;
    int t;
    // directed part
    queue_cmd(mk(drto_pkg::CmdClear, 0, 0, 0));
    queue_cmd(mk(drto_pkg::CmdAddEdge, 0, 63, 17));
    queue_cmd(mk(drto_pkg::CmdAddEdge, 63, 5, 63));
    queue_cmd(mk(drto_pkg::CmdAddEdge, 0, 5, 0));
    queue_cmd(mk(drto_pkg::CmdAddEdge, 0, 5, 42));
    queue_cmd(mk(drto_pkg::CmdRun, 63, 0, 0));
    queue_cmd(mk(drto_pkg::CmdRun, 0, 63, 63));
    queue_cmd(mk(drto_pkg::CmdRun, 21, 42, 5));
    queue_cmd(mk(drto_pkg::CmdRun, 0, 0, 40));
    queue_cmd(mk(drto_pkg::CmdAddEdge, 5, 5, 0));
    queue_cmd(mk(drto_pkg::CmdRun, 0, 0, 0));
    queue_cmd(mk(drto_pkg::CmdRun, 0, 0, 40));
    queue_cmd(mk(drto_pkg::CmdRsvd, 63, 63, 63));
    queue_cmd(mk(drto_pkg::CmdRun, 63, 63, 5));
    queue_cmd(mk(drto_pkg::CmdClear, 63, 63, 63));
    queue_cmd(mk(drto_pkg::CmdRun, 0, 0, 0));
    queue_cmd(mk(drto_pkg::CmdAddEdge, 10, 20, 0));
    queue_cmd(mk(drto_pkg::CmdAddEdge, 20, 10, 0));
    queue_cmd(mk(drto_pkg::CmdAddEdge, 10, 30, 0));
    queue_cmd(mk(drto_pkg::CmdRun, 0, 0, 10));
    queue_cmd(mk(drto_pkg::CmdRun, 0, 0, 30));
    queue_cmd(mk(drto_pkg::CmdClear, 42, 21, 7));
    // random graphs, mostly acyclic, each followed by runs
    while (cmd_queue.size() < 155) begin
      if ($urandom_range(0, 2) == 0) queue_cmd(noise_fields(drto_pkg::CmdClear));
      k = $urandom_range(2, 10);
      for (int i = 0; i < k; i++) nodes[i] = $urandom_range(0, 63);
      for (int e = $urandom_range(1, 2 * k); e > 0; e--) begin
        a = nodes[$urandom_range(0, k - 1)];
        b = nodes[$urandom_range(0, k - 1)];
        if ($urandom_range(0, 9) != 0 && a >= b) begin
          if (a == b) continue;
          t = a; a = b; b = t;
        end
        queue_cmd(mk(drto_pkg::CmdAddEdge, a, b, $urandom_range(0, 63)));
      end
      for (int r = $urandom_range(1, 3); r > 0; r--)
        queue_cmd(mk(drto_pkg::CmdRun, $urandom_range(0, 63), $urandom_range(0, 63),
                     nodes[$urandom_range(0, 1)]));
      if ($urandom_range(0, 4) == 0) queue_cmd(noise_fields(drto_pkg::CmdRsvd));
      if ($urandom_range(0, 5) == 0)
        queue_cmd(mk(drto_pkg::CmdRun, 0, 0, $urandom_range(0, 63)));
    end
    // one long chain near the end
    queue_cmd(mk(drto_pkg::CmdClear, 0, 0, 0));
    for (int i = 0; i < 63; i++) queue_cmd(mk(drto_pkg::CmdAddEdge, i, i + 1, 0));
    queue_cmd(mk(drto_pkg::CmdRun, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (cmd_queue.size() > 0 || in_ch.valid) @(posedge clk);
    draining = 1;
    while (redo_queue.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && redo_queue.size() == 0) begin
      $display("dependent_reach_topo_order_tb OK");
    end else begin
      $display("dependent_reach_topo_order_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/drto_pkg.sv
hw/rtl/drto_if.sv
hw/rtl/drto_ram.sv
hw/rtl/drto_datapath.sv
hw/rtl/drto_ctrl.sv
hw/rtl/dependent_reach_topo_order.sv
bench/dependent_reach_topo_order_tb.sv
